### hdl/utf8d_pkg.sv
// ----------------------------------------------------------------------------
// utf8d_pkg
// Shared types, constants and helper functions for the UTF-8 byte decoder.
// ----------------------------------------------------------------------------
package utf8d_pkg;

  localparam int BYTE_W = 8;
  localparam int CP_W   = 16;
  localparam int REM_W  = 3;

  // Two top bits of a lead byte.
  localparam logic [1:0] LEAD_TAG = 2'b11;
  // First byte value that is a lead.
  localparam logic [BYTE_W-1:0] LEAD_MIN = 8'hC0;
  localparam logic [BYTE_W-1:0] NUL_BYTE = 8'h00;

  typedef logic [BYTE_W-1:0] byte_t;
  typedef logic [CP_W-1:0]   cp_t;

  // Decoder state carried from one item to the next.
  typedef struct packed {
    byte_t            held;
    logic             pending;
    logic [REM_W-1:0] rem;
    cp_t              acc;
  } utf8d_state_t;

  // Count of set bits from bit 5 of the lead downward, up to the first clear bit.
  function automatic logic [1:0] extra_count(input byte_t lead);
    logic [1:0] k;
    k = 2'd0;
    if (lead[5]) begin
      k = 2'd1;
      if (lead[4]) begin
        k = 2'd2;
        if (lead[3]) begin
          k = 2'd3;
        end
      end
    end
    return k;
  endfunction

  // Lead payload bits placed above the continuation bits, cut to 16 bits.
  // For three or more continuation bytes they fall above bit 15 entirely.
  function automatic cp_t lead_bits(input byte_t lead, input logic [1:0] k);
    cp_t bits;
    unique case (k)
      2'd0:    bits = {5'd0, lead[4:0], 6'd0};
      2'd1:    bits = {lead[3:0], 12'd0};
      default: bits = '0;
    endcase
    return bits;
  endfunction

endpackage

### hdl/utf8_byte_stream_decoder_core.sv
// ----------------------------------------------------------------------------
// utf8_byte_stream_decoder_core
// UTF-8 byte stream to 16-bit code point decoder.
// ----------------------------------------------------------------------------
// The block takes one byte per cycle while in_stall is low and gives at most
// one code point per byte. A byte is captured in an input register, decoded
// from there by one shallow step of logic that also updates the sequence
// state, and a completed code point lands in the result register. Input and
// result stages advance together whenever the result register is free or
// being taken, so the sustained rate is one byte per cycle while out_stall
// stays low; a held result under out_stall stalls the input.
module utf8_byte_stream_decoder_core (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  utf8d_pkg::byte_t    in_byte_in,
  output logic                out_valid,
  input  logic                out_stall,
  output utf8d_pkg::cp_t      out_code_point
);
  import utf8d_pkg::*;

  logic         in_vld_r;
  byte_t        in_byte_r;
  utf8d_state_t st_r;
  utf8d_state_t st_nxt;
  logic         out_valid_r;
  cp_t          out_code_point_r;
  logic         emit;
  cp_t          code;
  logic         out_free;
  logic         step;

  utf8d_decode u_decode (
    .cur     (st_r),
    .byte_in (in_byte_r),
    .nxt     (st_nxt),
    .emit    (emit),
    .code    (code)
  );

  assign out_free = !out_valid_r || !out_stall;
  assign step     = in_vld_r && out_free;
  assign in_stall = in_vld_r && !out_free;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r    <= 1'b0;
      out_valid_r <= 1'b0;
      st_r        <= '0;
    end else begin
      if (!in_stall) begin
        in_vld_r <= in_valid;
      end
      if (step) begin
        st_r <= st_nxt;
      end
      if (out_free) begin
        out_valid_r <= step && emit;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      in_byte_r <= in_byte_in;
    end
    if (step && emit) begin
      out_code_point_r <= code;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_code_point = out_code_point_r;

endmodule

### hdl/utf8d_decode.sv
// ----------------------------------------------------------------------------
// utf8d_decode
// Next-state and result logic for one byte of the UTF-8 stream.
// ----------------------------------------------------------------------------
module utf8d_decode (
  input  utf8d_pkg::utf8d_state_t cur,
  input  utf8d_pkg::byte_t        byte_in,
  output utf8d_pkg::utf8d_state_t nxt,
  output logic                    emit,
  output utf8d_pkg::cp_t          code
);
  import utf8d_pkg::*;

  logic [1:0] k;
  cp_t        acc_sh;
  cp_t        first_cont;

  assign k          = extra_count(cur.held);
  assign acc_sh     = {cur.acc[CP_W-7:0], byte_in[5:0]};
  assign first_cont = {{(CP_W-6){1'b0}}, byte_in[5:0]};

  always_comb begin
    nxt  = cur;
    emit = 1'b0;
    code = '0;
    priority if (cur.rem != '0) begin
      nxt.acc = acc_sh;
      nxt.rem = cur.rem - REM_W'(1);
      if (cur.rem == REM_W'(1)) begin
        emit     = 1'b1;
        code     = acc_sh | lead_bits(cur.held, k);
        nxt.acc  = '0;
        nxt.held = '0;
      end
    end else if (cur.pending) begin
      if (byte_in[7:6] == LEAD_TAG) begin
        // A second lead flushes the first one on its own.
        emit     = 1'b1;
        code     = {{(CP_W-BYTE_W){1'b0}}, cur.held};
        nxt.held = byte_in;
      end else begin
        // Any other byte is the first continuation, even a plain ASCII one.
        nxt.pending = 1'b0;
        nxt.acc     = first_cont;
        nxt.rem     = {1'b0, k};
        if (k == 2'd0) begin
          emit     = 1'b1;
          code     = first_cont | lead_bits(cur.held, k);
          nxt.acc  = '0;
          nxt.held = '0;
        end
      end
    end else if (byte_in == NUL_BYTE) begin
      emit = 1'b0;
    end else if (byte_in < LEAD_MIN) begin
      emit = 1'b1;
      code = {{(CP_W-BYTE_W){1'b0}}, byte_in};
    end else begin
      nxt.held    = byte_in;
      nxt.pending = 1'b1;
    end
  end

endmodule
